// ===== hw/rtl/mmps_pkg.sv =====
// ----------------------------------------------------------------------------
// mmps_pkg
// Shared types and constants for the modular matrix power series block.
// ----------------------------------------------------------------------------
package mmps_pkg;

    localparam int MAX_DIM_DEF    = 8;
    localparam int VALUE_BITS_DEF = 16;

    localparam int DIM_W = 4;
    localparam int LEN_W = 30;
    localparam int MOD_W = 16;
    localparam int IDX_W = 2;

    localparam logic [IDX_W-1:0] REG_DIM = 2'd0;
    localparam logic [IDX_W-1:0] REG_LEN = 2'd1;
    localparam logic [IDX_W-1:0] REG_MOD = 2'd2;

    typedef enum logic [3:0] {
        S_LOAD,
        S_INIT,
        S_DECIDE,
        S_MAC_RD,
        S_MAC_RED,
        S_MAC_ACC,
        S_WB_RD,
        S_WB_WR,
        S_OUT_RD,
        S_OUT_FIX,
        S_OUT_EMIT
    } t_state;

endpackage

// ===== hw/rtl/modular_matrix_power_series_top.sv =====
// ----------------------------------------------------------------------------
// modular_matrix_power_series_top
// Sums A + A^2 + ... + A^k mod M by raising [[A,0],[I,I]] to power k+1.
// ----------------------------------------------------------------------------
// Loading: one element request per cycle; busy rises after the n*n-th one.
// Set-up: per entry of the (2n)^2 region, a read and a 17-step reduction.
// Compute: per matrix product (2n)^3 multiply-accumulates, each of two reads,
//   a multiply and a 17-step reduction mod M, plus a copy per entry (read,
//   write) and a decision state, up to two products per exponent bit.
// Output: n*n result strobes, each after a read and a fix state; then busy falls.
// Reset (synchronous, active low) clears the count, exponent, FSM and control
// registers, sets the config registers to 1; memories stay undefined until written.
// ----------------------------------------------------------------------------
module modular_matrix_power_series_top #(
    parameter int MAX_DIM    = mmps_pkg::MAX_DIM_DEF,
    parameter int VALUE_BITS = mmps_pkg::VALUE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [15:0]                 i_element_value,
    input  logic                        i_cfg_we,
    input  logic [mmps_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [29:0]                 i_cfg_data,
    output logic                        o_valid,
    output logic [15:0]                 o_sum_value,
    output logic                        o_last_element
);
    localparam int SIDE  = 2 * MAX_DIM;
    localparam int SW    = $clog2(SIDE);
    localparam int AW    = 2 * SW;
    localparam int CELLS = SIDE * SIDE;
    localparam int LW    = $clog2(MAX_DIM * MAX_DIM + 1);
    localparam int NW    = $clog2(SIDE + 1);
    localparam int PW    = 2 * VALUE_BITS;
    localparam int EW    = mmps_pkg::LEN_W + 1;
    localparam logic [15:0] VMASK = 16'((17'd1 << ((VALUE_BITS > 16) ? 16 : VALUE_BITS)) - 17'd1);

    // Configuration registers
    logic [mmps_pkg::DIM_W-1:0] r_dim;
    logic [mmps_pkg::LEN_W-1:0] r_len;
    logic [mmps_pkg::MOD_W-1:0] r_mod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= mmps_pkg::DIM_W'(1);
            r_len <= mmps_pkg::LEN_W'(1);
            r_mod <= mmps_pkg::MOD_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mmps_pkg::REG_DIM: r_dim <= i_cfg_data[mmps_pkg::DIM_W-1:0];
                mmps_pkg::REG_LEN: r_len <= i_cfg_data;
                mmps_pkg::REG_MOD: r_mod <= i_cfg_data[mmps_pkg::MOD_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective dimension and modulus
    logic [NW-1:0] n_eff;
    logic [NW-1:0] s_eff;
    logic [PW-1:0] m_eff;
    always_comb begin
        if (r_dim == '0) n_eff = NW'(1);
        else if (32'(r_dim) > MAX_DIM) n_eff = NW'(MAX_DIM);
        else n_eff = NW'(r_dim);
        s_eff = NW'(2 * n_eff);
        m_eff = (r_mod == '0) ? PW'(1) : PW'(r_mod);
    end
    logic one_mod;  // 1 % m
    assign one_mod = (m_eff != PW'(1));

    // Memories: base, accumulator, scratch. Each single port, registered read.
    logic [VALUE_BITS-1:0] mem_b [CELLS];
    logic [VALUE_BITS-1:0] mem_a [CELLS];
    logic [VALUE_BITS-1:0] mem_s [CELLS];
    logic [VALUE_BITS-1:0] rd_b, rd_a, rd_s;
    logic [AW-1:0] ad_b, ad_a, ad_s;
    logic we_b, we_a, we_s;
    logic [VALUE_BITS-1:0] wd_b, wd_a, wd_s;

    always_ff @(posedge i_clk) begin
        if (we_b) mem_b[ad_b] <= wd_b;
        rd_b <= mem_b[ad_b];
    end
    always_ff @(posedge i_clk) begin
        if (we_a) mem_a[ad_a] <= wd_a;
        rd_a <= mem_a[ad_a];
    end
    always_ff @(posedge i_clk) begin
        if (we_s) mem_s[ad_s] <= wd_s;
        rd_s <= mem_s[ad_s];
    end

    // Control state
    mmps_pkg::t_state r_st, n_st;
    logic [6:0]  r_cnt;
    logic [EW-1:0] r_exp;
    logic        r_sq;      // 0: acc*base, 1: base*base
    logic [SW-1:0] r_r, r_c, r_t;
    logic [PW-1:0] r_acc, r_prod;
    logic [VALUE_BITS-1:0] r_x;
    logic [PW-1:0] r_fix;
    // Phase within a cell: 0 = issue the read and start, 1 = reduce and write.
    logic        r_init_ph;

    // Reduction of a loaded element by one iterative compare-subtract is long;
    // elements are stored raw and reduced on use in the init copy below.
    logic [6:0] cnt_inc;
    assign cnt_inc = r_cnt + 7'd1;
    logic [LW:0] nn;
    assign nn = (LW+1)'(n_eff * n_eff);
    logic load_fire;
    assign load_fire = start && !busy;
    logic load_done;
    assign load_done = load_fire && ({1'b0, cnt_inc} >= 8'(nn));

    // Index helpers
    function automatic logic [AW-1:0] at(input logic [SW-1:0] r, input logic [SW-1:0] c);
        at = {r, c};
    endfunction

    // Multiply-accumulate operand selection: x from acc or base, y from base.
    // Operands x[r][t] and y[t][c] both come from the same memory when
    // squaring, so the two reads are sequenced: the x[r][t] read is issued in
    // S_MAC_RD and latched into r_x in S_MAC_RED, where the y[t][c] read is
    // issued; S_MAC_ACC then multiplies and accumulates.
    logic [PW-1:0] sum_w;
    logic [PW:0]   sum_ext;
    assign sum_ext = {1'b0, r_acc} + {1'b0, r_prod};

    // Init walk counters reuse r_r / r_c; output uses r_r / r_c too.
    logic last_rc, last_t;
    assign last_t  = ({1'b0, r_t} == NW'(s_eff - NW'(1)));
    assign last_rc = ({1'b0, r_c} == NW'(s_eff - NW'(1))) &&
                     ({1'b0, r_r} == NW'(s_eff - NW'(1)));

    // Modular reduction unit: r_prod holds raw product; reduce by iterative
    // restoring subtraction one bit per cycle.
    logic [5:0]  r_rb;
    logic [PW-1:0] r_rem;
    logic red_busy;
    assign red_busy = (r_rb != '0);
    logic [PW-1:0] rem_next;
    logic [PW:0]   rem_sh;
    always_comb begin
        rem_sh = {1'b0, r_rem} - ({1'b0, m_eff} << (r_rb - 6'd1));
        rem_next = rem_sh[PW] ? r_rem : rem_sh[PW-1:0];
    end

    // Sub-phase that starts a reduction (init element or acc + prod)
    logic r_red_go;

    always_comb begin
        n_st = r_st;
        case (r_st)
            mmps_pkg::S_LOAD:    if (load_done) n_st = mmps_pkg::S_INIT;
            mmps_pkg::S_INIT: begin
                if (last_rc && r_init_ph && !red_busy && !r_red_go)
                    n_st = mmps_pkg::S_DECIDE;
            end
            mmps_pkg::S_DECIDE: begin
                if (r_exp == '0) n_st = mmps_pkg::S_OUT_RD;
                else n_st = mmps_pkg::S_MAC_RD;
            end
            mmps_pkg::S_MAC_RD:  n_st = mmps_pkg::S_MAC_RED;
            mmps_pkg::S_MAC_RED: n_st = mmps_pkg::S_MAC_ACC;
            mmps_pkg::S_MAC_ACC: if (r_init_ph && !red_busy && !r_red_go) begin
                if (last_t && last_rc) n_st = mmps_pkg::S_WB_RD;
                else n_st = mmps_pkg::S_MAC_RD;
            end
            mmps_pkg::S_WB_RD:   n_st = mmps_pkg::S_WB_WR;
            mmps_pkg::S_WB_WR: begin
                if (last_rc) n_st = mmps_pkg::S_DECIDE;
                else n_st = mmps_pkg::S_WB_RD;
            end
            mmps_pkg::S_OUT_RD:  n_st = mmps_pkg::S_OUT_FIX;
            mmps_pkg::S_OUT_FIX: n_st = mmps_pkg::S_OUT_EMIT;
            mmps_pkg::S_OUT_EMIT: begin
                if ({1'b0, r_r} == NW'(n_eff - NW'(1)) && {1'b0, r_c} == NW'(n_eff - NW'(1)))
                    n_st = mmps_pkg::S_LOAD;
                else n_st = mmps_pkg::S_OUT_RD;
            end
            default: n_st = mmps_pkg::S_LOAD;
        endcase
    end

    assign busy = (r_st != mmps_pkg::S_LOAD);

    // Source of the init base value at (r,c): scratch entry r*n+c.
    logic [AW-1:0] lin_rc;
    assign lin_rc = AW'(32'(r_r) * 32'(n_eff) + 32'(r_c));
    logic in_a_blk, on_ldiag, on_rdiag, on_diag;
    assign in_a_blk = ({1'b0, r_r} < n_eff) && ({1'b0, r_c} < n_eff);
    assign on_ldiag = ({1'b0, r_r} >= n_eff) && (NW'(r_r) == NW'(n_eff + NW'(r_c)));
    assign on_rdiag = ({1'b0, r_r} >= n_eff) && (r_r == r_c);
    assign on_diag  = (r_r == r_c);

    // Memory port control
    always_comb begin
        ad_b = at(r_r, r_c); ad_a = at(r_r, r_c); ad_s = at(r_r, r_c);
        we_b = 1'b0; we_a = 1'b0; we_s = 1'b0;
        wd_b = '0; wd_a = '0; wd_s = '0;
        case (r_st)
            mmps_pkg::S_LOAD: begin
                ad_s = AW'(r_cnt);
                we_s = load_fire;
                wd_s = VALUE_BITS'(i_element_value & VMASK);
            end
            mmps_pkg::S_INIT: begin
                // Scratch read address is that of the current cell, r*n+c
                ad_s = lin_rc;
                we_a = r_red_go == 1'b0 && !red_busy && r_rb == '0 && r_init_ph;
                wd_a = (on_diag && one_mod) ? VALUE_BITS'(1) : '0;
                we_b = we_a;
                wd_b = in_a_blk ? VALUE_BITS'(r_rem) :
                       ((on_ldiag || on_rdiag) && one_mod) ? VALUE_BITS'(1) : '0;
            end
            mmps_pkg::S_MAC_RD: begin
                ad_b = r_sq ? at(r_r, r_t) : at(r_t, r_c);
                ad_a = at(r_r, r_t);
            end
            mmps_pkg::S_MAC_RED: begin
                ad_b = at(r_t, r_c);
            end
            mmps_pkg::S_MAC_ACC: begin
                ad_s = at(r_r, r_c);
                we_s = last_t && r_init_ph && !red_busy && !r_red_go;
                wd_s = VALUE_BITS'(r_rem);
            end
            mmps_pkg::S_WB_RD: ad_s = at(r_r, r_c);
            mmps_pkg::S_WB_WR: begin
                we_b = r_sq;  wd_b = rd_s;
                we_a = !r_sq; wd_a = rd_s;
            end
            mmps_pkg::S_OUT_RD: ad_a = at(SW'(32'(r_r) + 32'(n_eff)), r_c);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= mmps_pkg::S_LOAD;
            r_cnt <= '0;
            r_exp <= '0;
            r_sq <= 1'b0;
            r_r <= '0; r_c <= '0; r_t <= '0;
            r_rb <= '0;
            r_red_go <= 1'b0;
            r_init_ph <= 1'b0;
            o_valid <= 1'b0;
            o_last_element <= 1'b0;
        end else begin
            r_st <= n_st;
            o_valid <= 1'b0;
            if (red_busy) begin
                r_rem <= rem_next;
                r_rb <= r_rb - 6'd1;
            end
            case (r_st)
                mmps_pkg::S_LOAD: begin
                    if (load_fire) r_cnt <= load_done ? 7'd0 : cnt_inc;
                    r_r <= '0; r_c <= '0; r_init_ph <= 1'b0;
                    r_exp <= EW'(r_len) + EW'(1);
                end
                mmps_pkg::S_INIT: begin
                    if (!r_init_ph) begin
                        // scratch read for this cell is issued here; rd_s holds it in the r_red_go phase
                        r_red_go <= 1'b1;
                        r_init_ph <= 1'b1;
                    end else if (r_red_go) begin
                        r_red_go <= 1'b0;
                        r_rem <= in_a_blk ? PW'(rd_s) : '0;
                        r_rb <= 6'(VALUE_BITS + 1);
                    end else if (!red_busy) begin
                        r_init_ph <= 1'b0;
                        if ({1'b0, r_c} == NW'(s_eff - NW'(1))) begin
                            r_c <= '0; r_r <= r_r + SW'(1);
                        end else r_c <= r_c + SW'(1);
                    end
                end
                mmps_pkg::S_DECIDE: begin
                    r_r <= '0; r_c <= '0; r_t <= '0; r_acc <= '0;
                    // Skip the fold for an even exponent and go straight to squaring.
                    if (!r_sq && r_exp != '0 && !r_exp[0]) r_sq <= 1'b1;
                end
                mmps_pkg::S_MAC_RD: r_x <= '0;
                mmps_pkg::S_MAC_RED: r_x <= r_sq ? rd_b : rd_a;
                mmps_pkg::S_MAC_ACC: begin
                    if (!r_red_go && !red_busy && r_rb == '0 && !r_init_ph) begin
                        r_prod <= PW'(r_x) * PW'(rd_b);
                        r_red_go <= 1'b1;
                        r_init_ph <= 1'b1;
                    end else if (r_red_go) begin
                        r_red_go <= 1'b0;
                        r_rem <= sum_w;
                        // acc + prod stays below m * 2^VALUE_BITS
                        r_rb <= 6'(VALUE_BITS + 1);
                    end else if (!red_busy) begin
                        r_init_ph <= 1'b0;
                        r_acc <= last_t ? '0 : r_rem;
                        if (last_t) begin
                            r_t <= '0;
                            if (last_rc) begin
                                r_r <= '0; r_c <= '0;
                            end else if ({1'b0, r_c} == NW'(s_eff - NW'(1))) begin
                                r_c <= '0; r_r <= r_r + SW'(1);
                            end else r_c <= r_c + SW'(1);
                        end else r_t <= r_t + SW'(1);
                    end
                end
                mmps_pkg::S_WB_RD: ;
                mmps_pkg::S_WB_WR: begin
                    if (last_rc) begin
                        r_r <= '0; r_c <= '0;
                        if (!r_sq) r_sq <= 1'b1;
                        else begin r_sq <= 1'b0; r_exp <= r_exp >> 1; end
                    end else if ({1'b0, r_c} == NW'(s_eff - NW'(1))) begin
                        r_c <= '0; r_r <= r_r + SW'(1);
                    end else r_c <= r_c + SW'(1);
                end
                mmps_pkg::S_OUT_RD: ;
                mmps_pkg::S_OUT_FIX: begin
                    r_fix <= (on_diag) ?
                        ((rd_a == '0) ? m_eff - PW'(1) : PW'(rd_a) - PW'(1)) : PW'(rd_a);
                end
                mmps_pkg::S_OUT_EMIT: begin
                    o_valid <= 1'b1;
                    o_sum_value <= 16'(r_fix);
                    o_last_element <= ({1'b0, r_r} == NW'(n_eff - NW'(1))) &&
                                      ({1'b0, r_c} == NW'(n_eff - NW'(1)));
                    if ({1'b0, r_c} == NW'(n_eff - NW'(1))) begin
                        r_c <= '0;
                        r_r <= ({1'b0, r_r} == NW'(n_eff - NW'(1))) ? '0 : r_r + SW'(1);
                    end else r_c <= r_c + SW'(1);
                end
                default: ;
            endcase
        end
    end

    // acc + prod, both under 2^PW; acc < m so no overflow beyond PW+1 bits
    assign sum_w = sum_ext[PW] ? (sum_ext[PW-1:0] - m_eff) : sum_ext[PW-1:0];

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Checks the modular matrix power series block against its own predictor.
// ----------------------------------------------------------------------------
// Matrix elements go in as start/busy requests in random bursts.
// Register writes happen only while the block is idle.
// A scoreboard class predicts the series sum A + A^2 + ... + A^k mod M for
// every completed matrix and compares each result strobe, field by field,
// with the oldest expected element. Directed cases come first: zero modulus,
// zero dimension, zero and maximum series length, and a dimension change
// part-way through a load. Random phases follow: oversized and full-size
// first, then mostly small matrices with short series.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Predicts the series sum for each matrix and holds the expected results.
    class series_scoreboard;
        int unsigned dim_reg;
        int unsigned len_reg;
        int unsigned mod_reg;
        int unsigned loaded;
        bit [15:0] held [256];
        longint unsigned base [16][16];
        longint unsigned power [16][16];
        int unsigned side;
        longint unsigned m_eff;
        bit [16:0] sums_q [$];    // {sum_value, last_element}
        bit failed;

        function new();
            dim_reg = 1;
            len_reg = 1;
            mod_reg = 1;
            loaded  = 0;
            failed  = 0;
        endfunction

        function void write_reg(logic [mmps_pkg::IDX_W-1:0] idx, logic [29:0] data);
            case (idx)
                mmps_pkg::REG_DIM: dim_reg = 32'(data[3:0]);
                mmps_pkg::REG_LEN: len_reg = 32'(data);
                mmps_pkg::REG_MOD: mod_reg = 32'(data[15:0]);
                default: ;
            endcase
        endfunction

        // Square the base, or fold the base into the running power.
        function void multiply(bit into_power);
            longint unsigned t [16][16];
            longint unsigned s;
            for (int r = 0; r < side; r++) begin
                for (int c = 0; c < side; c++) begin
                    s = 0;
                    for (int k = 0; k < side; k++) begin
                        s = (s + (into_power ? power[r][k] : base[r][k]) * base[k][c]) % m_eff;
                    end
                    t[r][c] = s;
                end
            end
            for (int r = 0; r < side; r++) begin
                for (int c = 0; c < side; c++) begin
                    if (into_power) power[r][c] = t[r][c];
                    else base[r][c] = t[r][c];
                end
            end
        endfunction

        function void note_element(bit [15:0] v);
            int unsigned n;
            longint unsigned e;
            longint unsigned x;
            n = (dim_reg == 0) ? 1 : (dim_reg > 8) ? 8 : dim_reg;
            m_eff = (mod_reg == 0) ? 1 : mod_reg;
            held[loaded] = 16'(v % m_eff);
            loaded = (loaded + 1) & 127;
            if (loaded < n * n) return;
            side = 2 * n;
            for (int i = 0; i < side; i++) begin
                for (int j = 0; j < side; j++) begin
                    base[i][j]  = 0;
                    power[i][j] = (i == j) ? 1 % m_eff : 0;
                end
            end
            for (int i = 0; i < n; i++) begin
                for (int j = 0; j < n; j++) base[i][j] = held[i * n + j];
                base[n + i][i]     = 1 % m_eff;
                base[n + i][n + i] = 1 % m_eff;
            end
            e = longint'(len_reg) + 1;
            while (e > 0) begin
                if (e[0]) multiply(1'b1);
                multiply(1'b0);
                e >>= 1;
            end
            for (int i = 0; i < n; i++) begin
                for (int j = 0; j < n; j++) begin
                    x = power[n + i][j] % m_eff;
                    if (i == j) x = (x + m_eff - 1) % m_eff;
                    sums_q.push_back({x[15:0], (i == n - 1 && j == n - 1) ? 1'b1 : 1'b0});
                end
            end
            loaded = 0;
        endfunction

        function void check_sum(bit [15:0] v, bit last);
            bit [16:0] want;
            if (sums_q.size() == 0) begin
                $display("%0t: unexpected result sum_value=%0d last=%0d", $time, v, last);
                failed = 1;
                return;
            end
            want = sums_q.pop_front();
            if (want[16:1] !== v) begin
                $display("%0t: sum_value expected %0d actual %0d", $time, want[16:1], v);
                failed = 1;
            end
            if (want[0] !== last) begin
                $display("%0t: last_element expected %0d actual %0d", $time, want[0], last);
                failed = 1;
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [15:0]      i_element_value = '0;
    logic             i_cfg_we = 1'b0;
    logic [mmps_pkg::IDX_W-1:0] i_cfg_idx = '0;
    logic [29:0]      i_cfg_data = '0;
    logic             o_valid;
    logic [15:0]      o_sum_value;
    logic             o_last_element;

    series_scoreboard sb = new();
    int unsigned      sent = 0;

    modular_matrix_power_series_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_element_value(i_element_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_sum_value    (o_sum_value),
        .o_last_element (o_last_element)
    );

    always #4 i_clk = ~i_clk;

    // Sample results at the edge that ends their strobe cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_sum(o_sum_value, o_last_element);
    end

    // Hold until every expected result is out and the block has gone idle,
    // then let the tail of the output phase drain.
    task automatic wait_idle();
        while (sb.sums_q.size() != 0 || busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [mmps_pkg::IDX_W-1:0] idx, logic [29:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_we   <= 1'b0;
    endtask

    // Drop start first so no stale request is taken once the block idles.
    task automatic configure(int unsigned dim, int unsigned len, int unsigned modv);
        start <= 1'b0;
        wait_idle();
        write_reg(mmps_pkg::REG_DIM, 30'(dim));
        write_reg(mmps_pkg::REG_LEN, 30'(len));
        write_reg(mmps_pkg::REG_MOD, 30'(modv));
    endtask

    // Present one element request and hold it until accepted; then either
    // keep start high for the burst or drop it for a random gap.
    task automatic send_element(logic [15:0] v);
        start           <= 1'b1;
        i_element_value <= v;
        do @(posedge i_clk); while (busy);
        sb.note_element(v);
        sent++;
        if ($urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic send_matrix(int unsigned dim, int unsigned modv);
        int unsigned n;
        n = (dim == 0) ? 1 : (dim > 8) ? 8 : dim;
        for (int i = 0; i < n * n; i++) begin
            if ($urandom_range(0, 1) == 0 && modv > 1)
                send_element(16'($urandom_range(0, modv - 1)));
            else send_element(16'($urandom));
        end
    endtask

    initial begin
        int unsigned dim;
        int unsigned len;
        int unsigned modv;
        int unsigned pick;
        int unsigned phase;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero modulus acts as one: every sum is zero.
        configure(1, 1, 0);
        send_element(16'hFFFF);
        send_element(16'h0000);
        // Zero dimension acts as one; longest series at the widest modulus.
        configure(0, 30'h3FFFFFFF, 65535);
        send_element(16'hFFFF);
        send_element(16'h0001);
        // Empty series gives the zero matrix.
        configure(2, 0, 7);
        for (int i = 0; i < 4; i++) send_element(16'($urandom));
        // Shrink the dimension part-way through a load; the next element
        // then starts the computation on the first loaded element.
        configure(4, 3, 1000);
        for (int i = 0; i < 3; i++) send_element(16'($urandom));
        start <= 1'b0;
        wait_idle();
        write_reg(mmps_pkg::REG_DIM, 30'd1);
        send_element(16'h8000);

        // Random phases: oversized and full dimension first, then mostly small.
        phase = 0;
        while (sent < 230) begin
            if (phase == 0) dim = 15;
            else if (phase == 1) dim = 8;
            else dim = $urandom_range(1, 4);
            if (dim >= 8) len = $urandom_range(0, 3);
            else if (dim <= 2 && $urandom_range(0, 5) == 0) len = $urandom & 30'h3FFFFFFF;
            else len = $urandom_range(0, 60);
            pick = $urandom_range(0, 7);
            modv = (pick == 0) ? 0 : (pick == 1) ? 1 : (pick == 2) ? 65535 :
                   $urandom_range(2, 65535);
            start <= 1'b0;
            configure(dim, len, modv);
            repeat ((dim >= 8) ? 1 : $urandom_range(1, 3)) send_matrix(dim, modv);
            phase++;
        end
        start <= 1'b0;

        while (sb.sums_q.size() != 0 || busy) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (!sb.failed) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Cap the run well beyond the slowest correct run.
    initial begin
        #200ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/mmps_pkg.sv
hw/rtl/modular_matrix_power_series_top.sv
tb/sv/tb_top.sv
